// File: src/tcp_pkg.sv
// Package for the tridiagonal characteristic polynomial evaluator.
// Holds the shared widths, request codes, constants and the accumulator control type.
// No dependencies.
`default_nettype none

package tcp_pkg;

  localparam int unsigned MaxOrderDefault = 16;

  localparam int unsigned ReqW   = 2;
  localparam int unsigned IdxInW = 4;
  localparam int unsigned ValW   = 32;
  localparam int unsigned PolyW  = 64;
  localparam int unsigned OrdCfgW = 5;
  localparam int unsigned AccW   = 128;

  localparam logic [OrdCfgW-1:0] OrderReset = 5'd16;

  localparam logic [ReqW-1:0] ReqLoadDiag = 2'd0;
  localparam logic [ReqW-1:0] ReqLoadOff  = 2'd1;
  localparam logic [ReqW-1:0] ReqEval     = 2'd2;

  // The constant 1.0 in signed Q32.32.
  localparam logic [PolyW-1:0] OneQ32   = 64'h0000_0001_0000_0000;
  localparam logic [AccW-1:0]  AccRound = 128'h8000_0000;
  localparam logic [PolyW-1:0] PolyMax  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [PolyW-1:0] PolyMin  = 64'h8000_0000_0000_0000;

  localparam logic [2:0] MacLast = 3'd7;

  typedef enum logic [2:0] {
    Sh0  = 3'd0,
    Sh16 = 3'd1,
    Sh32 = 3'd2,
    Sh48 = 3'd3,
    Sh64 = 3'd4
  } shift_e;

  typedef struct packed {
    logic   init;
    logic   add;
    logic   neg;
    shift_e shift;
  } mac_op_t;

  typedef struct packed {
    logic diag;
    logic off;
  } store_we_t;

endpackage

`default_nettype wire

// File: src/tcp_if.sv
// Channel interfaces of the tridiagonal characteristic polynomial evaluator.
// Request, response and configuration channels with valid/ready handshakes.
// Depends on tcp_pkg.
`default_nettype none

interface tcp_req_if;
  logic                           valid;
  logic                           ready;
  logic [tcp_pkg::ReqW-1:0]       req_type;
  logic [tcp_pkg::IdxInW-1:0]     entry_index;
  logic signed [tcp_pkg::ValW-1:0] operand_value;

  modport source (output valid, req_type, entry_index, operand_value, input ready);
  modport sink (input valid, req_type, entry_index, operand_value, output ready);
endinterface

interface tcp_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [tcp_pkg::PolyW-1:0] poly_value;
  logic                             overflow;

  modport source (output valid, poly_value, overflow, input ready);
  modport sink (input valid, poly_value, overflow, output ready);
endinterface

interface tcp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tcp_pkg::OrdCfgW-1:0]   matrix_order;

  modport source (output valid, matrix_order, input ready);
  modport sink (input valid, matrix_order, output ready);
endinterface

`default_nettype wire

// File: src/tcp_store.sv
// Diagonal and off-diagonal entry memories with per-entry valid bits.
// Entries that were never written since reset read as zero; reads are registered.
// Depends on tcp_pkg.
`default_nettype none

module tcp_store #(
  parameter int unsigned MAX_ORDER = tcp_pkg::MaxOrderDefault
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  tcp_pkg::store_we_t                  we_i,
  input  wire [$clog2(MAX_ORDER)-1:0]         wr_addr_i,
  input  wire [tcp_pkg::ValW-1:0]             wr_data_i,
  input  wire [$clog2(MAX_ORDER)-1:0]         d_addr_i,
  input  wire [$clog2(MAX_ORDER)-1:0]         e_addr_i,
  output logic [tcp_pkg::ValW-1:0]            d_data_o,
  output logic [tcp_pkg::ValW-1:0]            e_data_o
);

  logic [tcp_pkg::ValW-1:0] d_mem [MAX_ORDER];
  logic [tcp_pkg::ValW-1:0] e_mem [MAX_ORDER-1];
  logic [MAX_ORDER-1:0]     d_vld_q;
  logic [MAX_ORDER-2:0]     e_vld_q;
  logic [tcp_pkg::ValW-1:0] d_rd_q;
  logic [tcp_pkg::ValW-1:0] e_rd_q;
  logic                     d_rd_vld_q;
  logic                     e_rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i.diag) begin
      d_mem[wr_addr_i] <= wr_data_i;
    end
    if (we_i.off) begin
      e_mem[wr_addr_i] <= wr_data_i;
    end
    d_rd_q <= d_mem[d_addr_i];
    e_rd_q <= e_mem[e_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q    <= '0;
      e_vld_q    <= '0;
      d_rd_vld_q <= 1'b0;
      e_rd_vld_q <= 1'b0;
    end else begin
      if (we_i.diag) begin
        d_vld_q[wr_addr_i] <= 1'b1;
      end
      if (we_i.off) begin
        e_vld_q[wr_addr_i] <= 1'b1;
      end
      d_rd_vld_q <= d_vld_q[d_addr_i];
      e_rd_vld_q <= e_vld_q[e_addr_i];
    end
  end

  assign d_data_o = d_rd_vld_q ? d_rd_q : '0;
  assign e_data_o = e_rd_vld_q ? e_rd_q : '0;

endmodule

`default_nettype wire

// File: src/tcp_mac.sv
// Shared 32x32 unsigned multiplier with a registered product and a 128-bit
// signed accumulator that adds or subtracts the shifted product in the cycle after.
// Depends on tcp_pkg.
`default_nettype none

module tcp_mac (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  tcp_pkg::mac_op_t            op_i,
  input  wire [31:0]                  opa_i,
  input  wire [31:0]                  opb_i,
  output logic [63:0]                 prod_o,
  output logic [tcp_pkg::AccW-1:0]    acc_o
);

  logic [63:0]               prod_q;
  logic [tcp_pkg::AccW-1:0]  acc_q;
  logic [tcp_pkg::AccW-1:0]  acc_d;
  logic                      tag_add_q;
  logic                      tag_neg_q;
  tcp_pkg::shift_e           tag_sh_q;
  logic [tcp_pkg::AccW-1:0]  ext;
  logic [tcp_pkg::AccW-1:0]  addend;
  logic [tcp_pkg::AccW-1:0]  term;

  assign ext = {64'b0, prod_q};

  always_comb begin
    unique case (tag_sh_q)
      tcp_pkg::Sh0:  addend = ext;
      tcp_pkg::Sh16: addend = ext << 16;
      tcp_pkg::Sh32: addend = ext << 32;
      tcp_pkg::Sh48: addend = ext << 48;
      tcp_pkg::Sh64: addend = ext << 64;
      default:       addend = '0;
    endcase
    term = addend ^ {tcp_pkg::AccW{tag_neg_q}};
    if (op_i.init) begin
      acc_d = tcp_pkg::AccRound;
    end else if (tag_add_q) begin
      acc_d = acc_q + term + {{(tcp_pkg::AccW-1){1'b0}}, tag_neg_q};
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= opa_i * opb_i;
    acc_q  <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_add_q <= 1'b0;
      tag_neg_q <= 1'b0;
      tag_sh_q  <= tcp_pkg::Sh0;
    end else begin
      tag_add_q <= op_i.add;
      tag_neg_q <= op_i.neg;
      tag_sh_q  <= op_i.shift;
    end
  end

  assign prod_o = prod_q;
  assign acc_o  = acc_q;

endmodule

`default_nettype wire

// File: src/tridiagonal_char_poly_eval_core.sv
// Top level of the tridiagonal characteristic polynomial evaluator.
// Sequencer for the recurrence, configuration register and output register.
// Depends on tcp_pkg, tcp_if, tcp_store and tcp_mac.
//
// Load transactions write one diagonal or off-diagonal entry and are taken one per
// cycle while idle; entries beyond the matrix order are dropped. Both stores read as zero
// after reset through per-entry valid bits, so no clearing pass is needed. An evaluate
// transaction returns det(A - lambda*I) in signed Q32.32, saturated, with a sticky
// overflow flag. Each recurrence step reads the entries, sets up the operands, makes
// seven 32x32 partial products on the one shared multiplier, drains the accumulator
// and saturates into the result. No request is accepted during an evaluation, but a
// new one is accepted while a finished result waits to be taken.
`default_nettype none

module tridiagonal_char_poly_eval_core #(
  parameter int unsigned MAX_ORDER = tcp_pkg::MaxOrderDefault
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  tcp_req_if.sink      req,
  tcp_rsp_if.source    rsp,
  tcp_cfg_if.sink      cfg
);

  localparam int unsigned IdxW = $clog2(MAX_ORDER);
  localparam int unsigned OrdW = $clog2(MAX_ORDER + 1);

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StInit  = 7'b0000010,
    StFetch = 7'b0000100,
    StPrep  = 7'b0001000,
    StMul   = 7'b0010000,
    StSat   = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  logic [OrdW-1:0]                step_q, step_d;
  logic [2:0]                     k_q, k_d;
  logic [tcp_pkg::OrdCfgW-1:0]    cfg_q;
  logic [OrdW-1:0]                ord;

  logic [tcp_pkg::ValW-1:0]       lam_q, lam_d;
  logic [tcp_pkg::PolyW-1:0]      p1_q, p1_d, p2_q, p2_d;
  logic                           ovf_q, ovf_d;
  logic [31:0]                    amag_q, amag_d, emag_q, emag_d;
  logic                           aneg_q, aneg_d;
  logic [63:0]                    e2_q, e2_d;
  logic [63:0]                    p1mag_q, p1mag_d, p2mag_q, p2mag_d;
  logic                           p1neg_q, p1neg_d, p2neg_q, p2neg_d;

  logic                           out_vld_q, out_vld_d;
  logic [tcp_pkg::PolyW-1:0]      out_poly_q, out_poly_d;
  logic                           out_ovf_q, out_ovf_d;

  logic                           req_acc;
  tcp_pkg::store_we_t             we;
  logic [IdxW-1:0]                d_addr, e_addr;
  logic [tcp_pkg::ValW-1:0]       d_data, e_data;
  tcp_pkg::mac_op_t               mop;
  logic [31:0]                    opa, opb;
  logic [63:0]                    prod;
  logic [tcp_pkg::AccW-1:0]       acc;

  logic [32:0]                    diff;
  logic [32:0]                    diff_neg;
  logic [tcp_pkg::PolyW-1:0]      res;
  logic                           res_ovf;

  // Order in use: zero acts as one, values above the store depth are clamped.
  always_comb begin
    if (cfg_q == '0) begin
      ord = OrdW'(1);
    end else if (32'(cfg_q) > 32'(MAX_ORDER)) begin
      ord = OrdW'(MAX_ORDER);
    end else begin
      ord = OrdW'(cfg_q);
    end
  end

  assign req.ready = (state_q == StIdle);
  assign cfg.ready = 1'b1;
  assign req_acc   = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tcp_pkg::OrderReset;
    end else if (cfg.valid && cfg.ready) begin
      cfg_q <= cfg.matrix_order;
    end
  end

  assign we.diag = req_acc && (req.req_type == tcp_pkg::ReqLoadDiag)
                   && (32'(req.entry_index) < 32'(ord));
  assign we.off  = req_acc && (req.req_type == tcp_pkg::ReqLoadOff)
                   && (32'(req.entry_index) + 32'd1 < 32'(ord));

  assign d_addr = ((state_q == StIdle) || (state_q == StDone)) ? '0
                  : IdxW'(step_q - OrdW'(1));
  assign e_addr = ((state_q == StIdle) || (state_q == StDone)) ? '0
                  : IdxW'(step_q - OrdW'(2));

  tcp_store #(
    .MAX_ORDER (MAX_ORDER)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (we),
    .wr_addr_i (IdxW'(req.entry_index)),
    .wr_data_i (req.operand_value),
    .d_addr_i  (d_addr),
    .e_addr_i  (e_addr),
    .d_data_o  (d_data),
    .e_data_o  (e_data)
  );

  tcp_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .op_i   (mop),
    .opa_i  (opa),
    .opb_i  (opb),
    .prod_o (prod),
    .acc_o  (acc)
  );

  assign diff     = {d_data[31], d_data} - {lam_q[31], lam_q};
  assign diff_neg = -diff;

  // Round already sits in the accumulator; take 32 fraction bits and saturate.
  always_comb begin
    res_ovf = !((&acc[127:95]) || !(|acc[127:95]));
    if (res_ovf) begin
      res = acc[127] ? tcp_pkg::PolyMin : tcp_pkg::PolyMax;
    end else begin
      res = acc[95:32];
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    k_d        = k_q;
    lam_d      = lam_q;
    p1_d       = p1_q;
    p2_d       = p2_q;
    ovf_d      = ovf_q;
    amag_d     = amag_q;
    aneg_d     = aneg_q;
    emag_d     = emag_q;
    e2_d       = e2_q;
    p1mag_d    = p1mag_q;
    p1neg_d    = p1neg_q;
    p2mag_d    = p2mag_q;
    p2neg_d    = p2neg_q;
    out_vld_d  = out_vld_q && !rsp.ready;
    out_poly_d = out_poly_q;
    out_ovf_d  = out_ovf_q;
    mop        = '{init: 1'b0, add: 1'b0, neg: 1'b0, shift: tcp_pkg::Sh0};
    opa        = amag_q;
    opb        = p1mag_q[31:0];

    unique case (state_q)
      StIdle: begin
        if (req_acc && (req.req_type == tcp_pkg::ReqEval)) begin
          lam_d   = req.operand_value;
          step_d  = OrdW'(2);
          state_d = StInit;
        end
      end
      StInit: begin
        p1_d  = {{15{diff[32]}}, diff, 16'b0};
        p2_d  = tcp_pkg::OneQ32;
        ovf_d = 1'b0;
        state_d = (ord == OrdW'(1)) ? StDone : StFetch;
      end
      StFetch: begin
        state_d = StPrep;
      end
      StPrep: begin
        aneg_d  = diff[32];
        amag_d  = diff[32] ? diff_neg[31:0] : diff[31:0];
        emag_d  = e_data[31] ? (~e_data + 32'd1) : e_data;
        p1neg_d = p1_q[63];
        p1mag_d = p1_q[63] ? (~p1_q + 64'd1) : p1_q;
        p2neg_d = p2_q[63];
        p2mag_d = p2_q[63] ? (~p2_q + 64'd1) : p2_q;
        mop.init = 1'b1;
        k_d     = '0;
        state_d = StMul;
      end
      StMul: begin
        unique case (k_q)
          3'd0: begin
            opa = emag_q;
            opb = emag_q;
          end
          3'd1: begin
            e2_d = prod;
            opa  = amag_q;
            opb  = p1mag_q[31:0];
            mop  = '{init: 1'b0, add: 1'b1, neg: aneg_q ^ p1neg_q, shift: tcp_pkg::Sh16};
          end
          3'd2: begin
            opa = amag_q;
            opb = p1mag_q[63:32];
            mop = '{init: 1'b0, add: 1'b1, neg: aneg_q ^ p1neg_q, shift: tcp_pkg::Sh48};
          end
          3'd3: begin
            opa = e2_q[31:0];
            opb = p2mag_q[31:0];
            mop = '{init: 1'b0, add: 1'b1, neg: !p2neg_q, shift: tcp_pkg::Sh0};
          end
          3'd4: begin
            opa = e2_q[31:0];
            opb = p2mag_q[63:32];
            mop = '{init: 1'b0, add: 1'b1, neg: !p2neg_q, shift: tcp_pkg::Sh32};
          end
          3'd5: begin
            opa = e2_q[63:32];
            opb = p2mag_q[31:0];
            mop = '{init: 1'b0, add: 1'b1, neg: !p2neg_q, shift: tcp_pkg::Sh32};
          end
          3'd6: begin
            opa = e2_q[63:32];
            opb = p2mag_q[63:32];
            mop = '{init: 1'b0, add: 1'b1, neg: !p2neg_q, shift: tcp_pkg::Sh64};
          end
          default: begin
            opa = amag_q;
            opb = p1mag_q[31:0];
          end
        endcase
        k_d = k_q + 3'd1;
        if (k_q == tcp_pkg::MacLast) begin
          state_d = StSat;
        end
      end
      StSat: begin
        p2_d    = p1_q;
        p1_d    = res;
        ovf_d   = ovf_q || res_ovf;
        step_d  = step_q + OrdW'(1);
        state_d = (step_q == ord) ? StDone : StFetch;
      end
      StDone: begin
        if (!out_vld_q || rsp.ready) begin
          out_vld_d  = 1'b1;
          out_poly_d = p1_q;
          out_ovf_d  = ovf_q;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      k_q       <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      k_q       <= k_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lam_q      <= lam_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    ovf_q      <= ovf_d;
    amag_q     <= amag_d;
    aneg_q     <= aneg_d;
    emag_q     <= emag_d;
    e2_q       <= e2_d;
    p1mag_q    <= p1mag_d;
    p1neg_q    <= p1neg_d;
    p2mag_q    <= p2mag_d;
    p2neg_q    <= p2neg_d;
    out_poly_q <= out_poly_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign rsp.valid      = out_vld_q;
  assign rsp.poly_value = out_poly_q;
  assign rsp.overflow   = out_ovf_q;

  a_init_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StInit) |-> $past(req.valid && req.ready && req.req_type == tcp_pkg::ReqEval))
    else $error("evaluation started without an evaluate transaction");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (step_q >= OrdW'(2) && step_q <= ord))
    else $error("recurrence step outside the matrix order");

  a_sat_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSat) |-> $past(state_q == StMul && k_q == tcp_pkg::MacLast))
    else $error("saturation before the accumulator drained");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp.valid) |-> $past(state_q == StDone))
    else $error("result presented outside the completion state");

endmodule

`default_nettype wire
